// ----- sv/psq_pkg.sv -----
// Shared types and constants for the per-owner sorted timeout queue.
`default_nettype none
package psq_pkg;
   localparam int DEF_QUEUE_DEPTH = 32;
   localparam int TIME_W   = 48;
   localparam int CFG_W    = 20;
   localparam int OWNER_W  = 8;
   localparam int STATUS_W = 3;
   localparam int MODE_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int MAX_EXPIRED = 32;
   localparam int EXP_CNT_W = 6;

   localparam logic [MODE_W-1:0] MODE_REL   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ABS   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;
   localparam logic [MODE_W-1:0] MODE_POLL  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_DONE_CODE   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SET_CODE    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL_CODE   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EXPIRE_CODE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_POLL_CODE   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DELAY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLACK     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN    = 2'd2;

   localparam logic [CFG_W-1:0] MIN_DELAY_RST = 20'd1000;
   localparam logic [CFG_W-1:0] SLACK_RST     = 20'd1000;
   localparam logic [CFG_W-1:0] MARGIN_RST    = 20'd0;

   typedef enum logic [2:0] {
      S_IDLE, S_EVAL, S_REMOVE, S_INSERT, S_FINISH, S_POP
   } state_type;

   typedef struct packed {
      logic                capture;
      logic                remove;
      logic                insert;
      logic                pop;
      logic                load_rsp;
      logic [STATUS_W-1:0] rsp_status;
      logic                rsp_last;
   } cmd_type;

   typedef struct packed {
      logic is_set;
      logic is_flush;
      logic ignore;
      logic full;
      logic expire;
      logic out_free;
   } flags_type;
endpackage
`default_nettype wire

// ----- sv/per_owner_sorted_timeout_queue.sv -----
// Top level of the per-owner sorted timeout queue.
// Requests arrive on req_* (valid/stall): mode, owner, time_value, now_us.
// Results leave on rsp_* (valid/stall), one or more per request; rsp_last
// marks the final result of a request. csr_* writes min delay (0), expiry
// slack (1) and wait margin (2); csr_ready is always high.
// The queue is a row of QUEUE_DEPTH compare-and-shift cells kept sorted by
// deadline. A request is taken only when the sequencer is idle:
//   ignored or full set: evaluate, then load the result register
//   accepted set: evaluate, remove owner, insert, report
//   flush: evaluate, remove owner, report; poll: evaluate, pop expired owners, report.
// A new request is taken in the cycle after the last result is registered.
// A result waits in the output register while rsp_stall is high; the
// sequencer holds until the register frees.
// Reset empties the queue and loads the register defaults; no clearing pass.
`default_nettype none
module per_owner_sorted_timeout_queue
   import psq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire [MODE_W-1:0]     req_mode,
   input  wire [OWNER_W-1:0]    req_owner,
   input  wire [TIME_W-1:0]     req_time_value,
   input  wire [TIME_W-1:0]     req_now_us,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [OWNER_W-1:0]   rsp_expired_owner,
   output logic [TIME_W-1:0]    rsp_wait_us,
   output logic                 rsp_queue_empty,
   output logic                 rsp_last,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CFG_W-1:0]      csr_data
);
   cmd_type   cmd;
   flags_type flags;

   assign csr_ready = 1'b1;

   psq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   psq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_mode          (req_mode),
      .req_owner         (req_owner),
      .req_time_value    (req_time_value),
      .req_now_us        (req_now_us),
      .csr_valid         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_expired_owner (rsp_expired_owner),
      .rsp_wait_us       (rsp_wait_us),
      .rsp_queue_empty   (rsp_queue_empty),
      .rsp_last          (rsp_last),
      .cmd               (cmd),
      .flags             (flags)
   );
endmodule
`default_nettype wire

// ----- sv/psq_ctrl.sv -----
// Sequencer for set, flush and poll requests.
`default_nettype none
module psq_ctrl
   import psq_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  flags_type  flags,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_EVAL;
         S_EVAL: begin
            if (flags.is_set) begin
               if (flags.ignore || flags.full) begin
                  if (flags.out_free) state_in = S_IDLE;
               end else begin
                  state_in = S_REMOVE;
               end
            end else if (flags.is_flush) begin
               state_in = S_REMOVE;
            end else begin
               state_in = S_POP;
            end
         end
         S_REMOVE: state_in = flags.is_set ? S_INSERT : S_FINISH;
         S_INSERT: state_in = S_FINISH;
         S_FINISH: if (flags.out_free) state_in = S_IDLE;
         S_POP:    if (!flags.expire && flags.out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: cmd.capture = req_valid;
         S_EVAL: begin
            if (flags.is_set && (flags.ignore || flags.full)) begin
               cmd.load_rsp   = flags.out_free;
               cmd.rsp_status = flags.ignore ? ST_DONE_CODE : ST_FULL_CODE;
               cmd.rsp_last   = 1'b1;
            end
         end
         S_REMOVE: cmd.remove = 1'b1;
         S_INSERT: cmd.insert = 1'b1;
         S_FINISH: begin
            cmd.load_rsp   = flags.out_free;
            cmd.rsp_status = flags.is_set ? ST_SET_CODE : ST_DONE_CODE;
            cmd.rsp_last   = 1'b1;
         end
         S_POP: begin
            cmd.load_rsp = flags.out_free;
            if (flags.expire) begin
               cmd.pop        = flags.out_free;
               cmd.rsp_status = ST_EXPIRE_CODE;
            end else begin
               cmd.rsp_status = ST_POLL_CODE;
               cmd.rsp_last   = 1'b1;
            end
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// ----- sv/psq_dp.sv -----
// Datapath: sorted compare-and-shift cells, config registers, result register.
`default_nettype none
module psq_dp
   import psq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire [MODE_W-1:0]     req_mode,
   input  wire [OWNER_W-1:0]    req_owner,
   input  wire [TIME_W-1:0]     req_time_value,
   input  wire [TIME_W-1:0]     req_now_us,
   input  wire                  csr_valid,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CFG_W-1:0]      csr_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [OWNER_W-1:0]   rsp_expired_owner,
   output logic [TIME_W-1:0]    rsp_wait_us,
   output logic                 rsp_queue_empty,
   output logic                 rsp_last,
   input  cmd_type              cmd,
   output flags_type            flags
);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CFG_W-1:0]   min_delay_ff, slack_ff, margin_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic [OWNER_W-1:0] owner_ff;
   logic [TIME_W-1:0]  tv_ff, now_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [EXP_CNT_W-1:0] nexp_ff;
   logic [TIME_W-1:0]  dl_ff [QUEUE_DEPTH];
   logic [OWNER_W-1:0] own_ff [QUEUE_DEPTH];
   logic [TIME_W-1:0]  dl_in [QUEUE_DEPTH];
   logic [OWNER_W-1:0] own_in [QUEUE_DEPTH];

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [OWNER_W-1:0]  rowner_ff;
   logic [TIME_W-1:0]   wait_ff;
   logic                empty_ff, last_ff;

   logic [TIME_W:0]   sum_rel, exp_sum, tgt_sum, wait_diff;
   logic [TIME_W-1:0] new_dl, wait_val;
   logic [QUEUE_DEPTH-1:0] cell_valid, match, rm_pre, ge;
   logic any_match, acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_delay_ff <= MIN_DELAY_RST;
         slack_ff     <= SLACK_RST;
         margin_ff    <= MARGIN_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_DELAY: min_delay_ff <= csr_data;
            CSR_SLACK:     slack_ff     <= csr_data;
            CSR_MARGIN:    margin_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         owner_ff <= req_owner;
         tv_ff    <= req_time_value;
         now_ff   <= req_now_us;
      end
   end

   assign sum_rel = {1'b0, now_ff} + {1'b0, tv_ff};
   assign new_dl  = (mode_ff == MODE_REL) ? (sum_rel[TIME_W] ? '1 : sum_rel[TIME_W-1:0])
                                          : tv_ff;

   always_comb begin
      acc = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         cell_valid[i] = (CNT_W'(i) < count_ff);
         match[i]      = cell_valid[i] && (own_ff[i] == owner_ff);
         acc           = acc | match[i];
         rm_pre[i]     = acc;
         ge[i]         = !cell_valid[i] || (dl_ff[i] >= new_dl);
      end
      any_match = acc;
   end

   assign exp_sum  = {1'b0, dl_ff[0]} + {{(TIME_W+1-CFG_W){1'b0}}, slack_ff};
   assign tgt_sum  = {1'b0, dl_ff[0]} + {{(TIME_W+1-CFG_W){1'b0}}, margin_ff};
   assign wait_diff = tgt_sum - {1'b0, now_ff};
   assign wait_val = (count_ff == '0 || tgt_sum <= {1'b0, now_ff}) ? '0 :
                     (wait_diff[TIME_W] ? '1 : wait_diff[TIME_W-1:0]);

   assign flags.is_set   = (mode_ff == MODE_REL) || (mode_ff == MODE_ABS);
   assign flags.is_flush = (mode_ff == MODE_FLUSH);
   assign flags.ignore   = (mode_ff == MODE_REL)
                         ? (tv_ff <= {{(TIME_W-CFG_W){1'b0}}, min_delay_ff})
                         : (tv_ff < now_ff);
   assign flags.full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign flags.expire   = (count_ff != '0) && (nexp_ff != EXP_CNT_W'(MAX_EXPIRED))
                         && (exp_sum < {1'b0, now_ff});
   assign flags.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         dl_in[i]  = dl_ff[i];
         own_in[i] = own_ff[i];
      end
      if (cmd.remove) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if (rm_pre[i]) begin
               dl_in[i]  = dl_ff[i+1];
               own_in[i] = own_ff[i+1];
            end
         end
         if (any_match) count_in = count_ff - 1'b1;
      end else if (cmd.insert) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (ge[i] && (i == 0 || !ge[(i == 0) ? 0 : i-1])) begin
               dl_in[i]  = new_dl;
               own_in[i] = owner_ff;
            end else if (ge[i]) begin
               dl_in[i]  = dl_ff[(i == 0) ? 0 : i-1];
               own_in[i] = own_ff[(i == 0) ? 0 : i-1];
            end
         end
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            dl_in[i]  = dl_ff[i+1];
            own_in[i] = own_ff[i+1];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         dl_ff[i]  <= dl_in[i];
         own_ff[i] <= own_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         nexp_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (cmd.capture)  nexp_ff <= '0;
         else if (cmd.pop) nexp_ff <= nexp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff <= cmd.rsp_status;
         rowner_ff <= (cmd.rsp_status == ST_EXPIRE_CODE) ? own_ff[0] : '0;
         wait_ff   <= (cmd.rsp_status == ST_POLL_CODE) ? wait_val : '0;
         empty_ff  <= (count_in == '0);
         last_ff   <= cmd.rsp_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_expired_owner = rowner_ff;
   assign rsp_wait_us       = wait_ff;
   assign rsp_queue_empty   = empty_ff;
   assign rsp_last          = last_ff;
endmodule
`default_nettype wire
